// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the bih_queue and bih_modulo RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bih_pkg.sv =====
package bih_pkg;

  localparam int ACC_W   = 64;
  localparam int BKT_W   = 32;
  localparam int BYTE_W  = 8;
  localparam int CNT_W   = $clog2(ACC_W);
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = 1'b1;

  localparam logic [BYTE_W-1:0] UPPER_A = 8'h41;
  localparam logic [BYTE_W-1:0] UPPER_Z = 8'h5A;
  localparam logic [BYTE_W-1:0] CASE_OFS = 8'h20;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_DONE
  } bk_state_t;

  typedef struct packed {
    logic             valid;
    logic [ACC_W-1:0] acc;
  } hq_push_t;

  typedef struct packed {
    logic empty;
    logic full;
  } hq_stat_t;

endpackage

// ===== rtl/bih_front.sv =====
module bih_front
  import bih_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              mode,
  input  logic              in_valid,
  input  logic [BYTE_W-1:0] in_key_byte,
  input  logic              in_last_byte,
  input  hq_stat_t          hq_stat,
  output logic              in_stall,
  output hq_push_t          hq_push
);

  logic [ACC_W-1:0]  acc_r;
  logic [ACC_W-1:0]  acc_nxt;
  logic              zero_seen_r;
  logic              zero_seen_nxt;
  logic              accept;
  logic [BYTE_W-1:0] folded;
  logic [ACC_W-1:0]  sext_raw;
  logic [ACC_W-1:0]  sext_fold;
  logic [ACC_W-1:0]  acc_sh5;
  logic [ACC_W-1:0]  acc_upd;
  logic              zero_upd;

  assign in_stall = hq_stat.full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    folded = in_key_byte;
    if (in_key_byte >= UPPER_A && in_key_byte <= UPPER_Z) begin
      folded = in_key_byte + CASE_OFS;
    end
  end

  assign sext_raw  = {{(ACC_W-BYTE_W){in_key_byte[BYTE_W-1]}}, in_key_byte};
  assign sext_fold = {{(ACC_W-BYTE_W){folded[BYTE_W-1]}}, folded};
  assign acc_sh5   = acc_r << 5;

  always_comb begin
    acc_upd  = acc_r;
    zero_upd = zero_seen_r;
    if (!mode) begin
      acc_upd = acc_sh5 + acc_r + sext_raw;
    end else if (!zero_seen_r) begin
      if (in_key_byte == '0) begin
        zero_upd = 1'b1;
      end else begin
        acc_upd = acc_sh5 - acc_r + sext_fold;
      end
    end
  end

  always_comb begin
    acc_nxt       = acc_r;
    zero_seen_nxt = zero_seen_r;
    if (accept) begin
      if (in_last_byte) begin
        acc_nxt       = '0;
        zero_seen_nxt = 1'b0;
      end else begin
        acc_nxt       = acc_upd;
        zero_seen_nxt = zero_upd;
      end
    end
  end

  assign hq_push.valid = accept && in_last_byte;
  assign hq_push.acc   = acc_upd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      zero_seen_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      zero_seen_r <= zero_seen_nxt;
    end
  end

endmodule

// ===== rtl/bih_queue.sv =====
`include "assert_macros.svh"

module bih_queue
  import bih_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  hq_push_t         hq_push,
  input  logic             pop,
  output hq_stat_t         hq_stat,
  output logic [ACC_W-1:0] head
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_QW = $clog2(DEPTH + 1);

  logic [ACC_W-1:0]  slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_nxt;
  logic [CNT_QW-1:0] cnt_r;
  logic [CNT_QW-1:0] cnt_nxt;

  assign hq_stat.empty = (cnt_r == '0);
  assign hq_stat.full  = (cnt_r == CNT_QW'(DEPTH));
  assign head          = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (hq_push.valid) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (hq_push.valid && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!hq_push.valid && pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (hq_push.valid) begin
      slot_r[wr_ptr_r] <= hq_push.acc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  `ASSERT_IMPLIES(a_no_pop_empty, pop, !hq_stat.empty, "queue popped while empty")
  `ASSERT_IMPLIES(a_no_push_full, hq_push.valid, !hq_stat.full, "queue pushed while full")
  `ASSERT_ALWAYS(a_ptr_count, (wr_ptr_r == rd_ptr_r) == (hq_stat.empty || hq_stat.full), "queue pointers disagree with count")

endmodule

// ===== rtl/bih_modulo.sv =====
`include "assert_macros.svh"

module bih_modulo
  import bih_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [BKT_W-1:0] table_size,
  input  hq_stat_t         hq_stat,
  input  logic [ACC_W-1:0] head,
  output logic             pop,
  output logic             out_valid,
  output logic [BKT_W-1:0] out_bucket,
  input  logic             out_stall
);

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ACC_W - 1);

  bk_state_t        state_r;
  bk_state_t        state_nxt;
  logic [ACC_W-1:0] dvd_r;
  logic [BKT_W-1:0] rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic [BKT_W-1:0] out_bucket_r;
  logic             out_free;
  logic             run;
  logic             load_out;
  logic [BKT_W:0]   trial;
  logic             ge;
  logic [BKT_W:0]   diff;
  logic [BKT_W-1:0] rem_step;

  assign out_free = !out_valid_r || !out_stall;

  assign trial    = {rem_r, dvd_r[ACC_W-1]};
  assign diff     = trial - {1'b0, table_size};
  assign ge       = !diff[BKT_W] || trial[BKT_W];
  assign rem_step = ge ? diff[BKT_W-1:0] : trial[BKT_W-1:0];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (!hq_stat.empty) begin
          state_nxt = BK_RUN;
        end
      end
      BK_RUN: begin
        if (cnt_r == CNT_LAST) begin
          state_nxt = BK_DONE;
        end
      end
      BK_DONE: begin
        if (out_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    run      = 1'b0;
    load_out = 1'b0;
    unique case (state_r)
      BK_IDLE: pop      = !hq_stat.empty;
      BK_RUN:  run      = 1'b1;
      BK_DONE: load_out = out_free;
      default: run      = 1'b0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      dvd_r <= head;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (run) begin
      dvd_r <= dvd_r << 1;
      rem_r <= rem_step;
      cnt_r <= cnt_r + 1'b1;
    end
    if (load_out) begin
      out_bucket_r <= (table_size == '0) ? '0 : rem_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_bucket = out_bucket_r;

  `ASSERT_IMPLIES(a_rem_below_div, (state_r == BK_DONE) && (table_size != '0), rem_r < table_size, "remainder not reduced")
  `ASSERT_IMPLIES(a_pop_only_idle, pop, state_r == BK_IDLE, "queue popped while divider busy")

endmodule

// ===== rtl/bucket_index_hash_unit.sv =====
// The last byte pushes the accumulator into the queue; the idle divider pops it, runs its
// shift-subtract steps, then registers the bucket and raises out_valid.
// One key byte per cycle while in_stall (queue full) is low; the modulo unit is a shift-subtract
// divider taking one quotient bit per cycle; a new key is popped only when the divider is idle.
// A two-entry queue lets later keys accumulate while the divider works.
// Reset (rst_n low, synchronous) clears the accumulator, queue, divider and output valid,
// and sets mode to 0 and table_size to 1.
module bucket_index_hash_unit
  import bih_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  input  logic [BYTE_W-1:0]     in_key_byte,
  input  logic                  in_last_byte,
  output logic                  in_stall,
  output logic                  out_valid,
  output logic [BKT_W-1:0]      out_bucket,
  input  logic                  out_stall
);

  logic             mode_r;
  logic             mode_nxt;
  logic [BKT_W-1:0] table_size_r;
  logic [BKT_W-1:0] table_size_nxt;
  hq_push_t         hq_push;
  hq_stat_t         hq_stat;
  logic             pop;
  logic [ACC_W-1:0] head;

  always_comb begin
    mode_nxt       = mode_r;
    table_size_nxt = table_size_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:       mode_nxt       = cfg_wdata[0];
        CFG_TABLE_SIZE: table_size_nxt = cfg_wdata[BKT_W-1:0];
        default:        mode_nxt       = mode_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= 1'b0;
      table_size_r <= BKT_W'(1);
    end else begin
      mode_r       <= mode_nxt;
      table_size_r <= table_size_nxt;
    end
  end

  bih_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .mode         (mode_r),
    .in_valid     (in_valid),
    .in_key_byte  (in_key_byte),
    .in_last_byte (in_last_byte),
    .hq_stat      (hq_stat),
    .in_stall     (in_stall),
    .hq_push      (hq_push)
  );

  bih_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .hq_push (hq_push),
    .pop     (pop),
    .hq_stat (hq_stat),
    .head    (head)
  );

  bih_modulo u_modulo (
    .clk        (clk),
    .rst_n      (rst_n),
    .table_size (table_size_r),
    .hq_stat    (hq_stat),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_bucket (out_bucket),
    .out_stall  (out_stall)
  );

endmodule
